[rtl/itoa_pkg.sv]
// Shared types, constants and helpers for the integer to ASCII converter.
package itoa_pkg;

	// Accepted number bases as they arrive on the input.
	localparam logic [7:0] RADIX_OCT = 8'd8;
	localparam logic [7:0] RADIX_DEC = 8'd10;
	localparam logic [7:0] RADIX_HEX = 8'd16;

	// Characters.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h41;

	// Decimal divider: quotient bits resolved per cycle.
	localparam int DIV_STEPS = 16;

	// Command queue depth between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_OCT,
		KIND_DEC,
		KIND_HEX
	} kind_t;

	typedef struct packed {
		logic        reject; // bad radix or no room
		kind_t       kind;
		logic        sign;   // negative decimal: leading minus
		logic [7:0]  room;   // room left for digits and NUL, sign removed
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_PLAN,
		ST_EMIT,
		ST_REJECT
	} back_state_t;

	function automatic logic [7:0] digit_ascii(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'b0000, d};
		end else begin
			c = CH_A + {4'b0000, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

[rtl/itoa_queue.sv]
// Short command queue between the front classifier and the digit back end.
module itoa_queue #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  itoa_pkg::cmd_t         push_cmd,
	input  logic [VALUE_WIDTH-1:0] push_mag,
	output logic                   full,
	input  logic                   pop,
	output logic                   head_valid,
	output itoa_pkg::cmd_t         head_cmd,
	output logic [VALUE_WIDTH-1:0] head_mag
);
	import itoa_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t                   cmd_q [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] mag_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_push, do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = cmd_q[rd_ptr_q];
	assign head_mag   = mag_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_q[wr_ptr_q] <= push_cmd;
			mag_q[wr_ptr_q] <= push_mag;
		end
	end

endmodule

[rtl/itoa_front.sv]
// Front end: accepts input beats, classifies them and queues a command.
module itoa_front #(
	parameter int VALUE_WIDTH = 32,
	parameter int S_W = ((VALUE_WIDTH + 16 + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_W-1:0]         s_tdata,
	input  logic                   q_pop,
	output logic                   q_valid,
	output itoa_pkg::cmd_t         q_cmd,
	output logic [VALUE_WIDTH-1:0] q_mag
);
	import itoa_pkg::*;

	logic [VALUE_WIDTH-1:0] raw;
	logic [7:0]             radix;
	logic [7:0]             room;
	logic                   bad_radix;
	logic                   neg_dec;
	kind_t                  kind;
	cmd_t                   cmd;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   full;

	assign raw   = s_tdata[VALUE_WIDTH-1:0];
	assign radix = s_tdata[VALUE_WIDTH+7:VALUE_WIDTH];
	assign room  = s_tdata[VALUE_WIDTH+15:VALUE_WIDTH+8];

	always_comb begin
		bad_radix = 1'b0;
		unique case (radix)
			RADIX_OCT: kind = KIND_OCT;
			RADIX_DEC: kind = KIND_DEC;
			RADIX_HEX: kind = KIND_HEX;
			default: begin
				kind      = KIND_DEC;
				bad_radix = 1'b1;
			end
		endcase
	end

	// Only decimal negatives print a sign; octal and hex keep the raw pattern.
	assign neg_dec = !bad_radix && (kind == KIND_DEC) && raw[VALUE_WIDTH-1];
	assign mag     = neg_dec ? (~raw + 1'b1) : raw;

	always_comb begin
		cmd.reject = bad_radix || (room == 8'd0);
		cmd.kind   = kind;
		cmd.sign   = neg_dec;
		cmd.room   = room - {7'b0000000, neg_dec};
	end

	assign s_tready = !full;

	itoa_queue #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_cmd  (cmd),
		.push_mag  (mag),
		.full      (full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_cmd  (q_cmd),
		.head_mag  (q_mag)
	);

endmodule

[rtl/itoa_back.sv]
// Back end: extracts digits low first, then emits the text high first.
module itoa_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  itoa_pkg::cmd_t         q_cmd,
	input  logic [VALUE_WIDTH-1:0] q_mag,
	output logic                   q_pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [7:0]             m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);
	import itoa_pkg::*;

	// Octal gives the most digits.
	localparam int DEPTH = (VALUE_WIDTH + 2) / 3;
	localparam int DIG_IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ND_W = $clog2(DEPTH + 1);
	// Work register padded up to whole division chunks.
	localparam int WP = ((VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
	localparam int CW = $clog2(WP + 1);
	// Chunk divide by 10: floor(v * RECIP / 2^RECIP_SH) is exact for v < 10 * 2^DIV_STEPS.
	localparam int VW = DIV_STEPS + 4;
	localparam int RECIP_SH = DIV_STEPS + 7;
	localparam logic [VW-1:0] RECIP = VW'(((64'd1 << RECIP_SH) + 64'd9) / 64'd10);

	back_state_t            state_q, state_d;
	kind_t                  kind_q;
	logic                   sign_q;
	logic [7:0]             room_q;
	logic [WP-1:0]          work_q;
	logic [3:0]             rem_q;
	logic [CW-1:0]          bcnt_q;
	logic [3:0]             dig_q [DEPTH];
	logic [ND_W-1:0]        nd_q;
	logic [ND_W-1:0]        idx_q;
	logic                   sign_pend_q, nul_pend_q;
	logic                   m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [7:0]             m_tdata_q;

	logic                   out_free;
	logic                   emit_fire, emit_last, emit_user;
	logic [7:0]             emit_char;
	logic [WP-1:0]          work_n;
	logic [3:0]             rem_n;
	logic [3:0]             dig_val;
	logic                   dig_step, dig_last;
	logic [ND_W-1:0]        keep;
	logic                   room_left;

	assign out_free = !m_tvalid_q || m_tready;

	// Digit datapath: decimal long division by 10, DIV_STEPS bits a cycle by a
	// reciprocal multiply; octal and hex peel one digit a cycle.
	always_comb begin
		logic [WP-1:0]        w;
		logic [3:0]           r;
		logic [VW-1:0]        v;
		logic [2*VW-1:0]      p;
		logic [DIV_STEPS-1:0] qc;
		logic [VW-1:0]        rv;
		w        = work_q;
		r        = rem_q;
		v        = '0;
		p        = '0;
		qc       = '0;
		rv       = '0;
		dig_val  = 4'd0;
		dig_step = 1'b1;
		case (kind_q)
			KIND_DEC: begin
				// running remainder on top of the next chunk, high chunk first
				v        = {r, w[WP-1 -: DIV_STEPS]};
				p        = {{VW{1'b0}}, v} * {{VW{1'b0}}, RECIP};
				qc       = p[RECIP_SH +: DIV_STEPS];
				rv       = v - VW'({qc, 3'b000}) - VW'({qc, 1'b0});
				r        = rv[3:0];
				w        = (w << DIV_STEPS) | WP'(qc);
				dig_step = (int'(bcnt_q) + DIV_STEPS >= WP);
				dig_val  = r;
			end
			KIND_OCT: begin
				dig_val = {1'b0, work_q[2:0]};
				w       = work_q >> 3;
			end
			KIND_HEX: begin
				dig_val = work_q[3:0];
				w       = work_q >> 4;
			end
			default: begin
				dig_val = 4'd0;
				w       = '0;
			end
		endcase
		work_n   = w;
		rem_n    = r;
		dig_last = (w == '0);
	end

	assign room_left = ({{(8 - ND_W){1'b0}}, nd_q} < room_q);
	assign keep      = room_left ? nd_q : room_q[ND_W-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = q_cmd.reject ? ST_REJECT : ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (dig_step && dig_last) begin
					state_d = ST_PLAN;
				end
			end
			ST_PLAN:   state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_fire && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_REJECT: begin
				if (emit_fire) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		q_pop     = 1'b0;
		emit_fire = 1'b0;
		emit_char = CH_NUL;
		emit_user = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: q_pop = q_valid;
			ST_REJECT: begin
				emit_fire = out_free;
				emit_user = 1'b1;
				emit_last = 1'b1;
			end
			ST_EMIT: begin
				emit_fire = out_free;
				if (sign_pend_q) begin
					emit_char = CH_MINUS;
					emit_last = (idx_q == '0) && !nul_pend_q;
				end else if (idx_q != '0) begin
					emit_char = digit_ascii(dig_q[DIG_IW'(idx_q - 1'b1)]);
					emit_last = (idx_q == ND_W'(1)) && !nul_pend_q;
				end else begin
					emit_char = CH_NUL;
					emit_last = 1'b1;
				end
			end
			ST_DIGIT, ST_PLAN: begin
				emit_fire = 1'b0;
			end
			default: begin
				emit_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			m_tvalid_q  <= 1'b0;
			sign_pend_q <= 1'b0;
			nul_pend_q  <= 1'b0;
			idx_q       <= '0;
			nd_q        <= '0;
		end else begin
			state_q <= state_d;
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (q_pop) begin
				nd_q <= '0;
			end else if (state_q == ST_DIGIT && dig_step) begin
				nd_q <= nd_q + 1'b1;
			end
			if (state_q == ST_PLAN) begin
				idx_q       <= keep;
				sign_pend_q <= sign_q;
				nul_pend_q  <= room_left;
			end else if (state_q == ST_EMIT && emit_fire) begin
				if (sign_pend_q) begin
					sign_pend_q <= 1'b0;
				end else if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end else begin
					nul_pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= q_cmd.kind;
			sign_q <= q_cmd.sign;
			room_q <= q_cmd.room;
			work_q <= WP'(q_mag);
			rem_q  <= 4'd0;
			bcnt_q <= '0;
		end else if (state_q == ST_DIGIT) begin
			work_q <= work_n;
			if (dig_step) begin
				dig_q[nd_q[DIG_IW-1:0]] <= dig_val;
				rem_q                   <= 4'd0;
				bcnt_q                  <= '0;
			end else begin
				rem_q  <= rem_n;
				bcnt_q <= bcnt_q + CW'(DIV_STEPS);
			end
		end
		if (emit_fire) begin
			m_tdata_q <= emit_char;
			m_tuser_q <= emit_user;
			m_tlast_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

[rtl/integer_to_ascii_radix.sv]
// Sequence: the input beat enters the queue; the back end pops it in idle, extracts the
//   digits (oct/hex one per step, decimal by chunked long division), plans, then emits.
// The back end finishes one item before popping the next; decimal digit extraction (16
//   quotient bits a cycle) dominates, and the 2-deep queue hides accepts meanwhile.
// Reset: arst_n asynchronous active low clears the sequencer, queue and output valid.
// Top level: accepts one integer, returns its ASCII text one character per beat.
module integer_to_ascii_radix #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input beats.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata, low bit up: value[VALUE_WIDTH], radix[8], max_chars[8], zero pad to bytes
	input  logic [((VALUE_WIDTH + 16 + 7) / 8) * 8 - 1:0] s_tdata,
	// Result beats.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata, low bit up: char_out[8]
	output logic [7:0]            m_tdata,
	// m_tuser, low bit up: status[1] (1 = request rejected)
	output logic                  m_tuser,
	// tlast marks the final beat of one conversion
	output logic                  m_tlast
);
	import itoa_pkg::*;

	localparam int S_W = ((VALUE_WIDTH + 16 + 7) / 8) * 8;

	logic                   q_pop;
	logic                   q_valid;
	cmd_t                   q_cmd;
	logic [VALUE_WIDTH-1:0] q_mag;

	// Front: decode radix, reject bad requests, take decimal magnitude, queue.
	itoa_front #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.S_W        (S_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_pop   (q_pop),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_mag   (q_mag)
	);

	// Back: digits low first into a small buffer, then sign, kept digits and, if room is left, NUL.
	itoa_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_mag   (q_mag),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

[rtl/itoa_checker.sv]
// Port-level checker for the integer to ASCII converter, with its bind.
module itoa_checker #(
	parameter int VALUE_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [((VALUE_WIDTH + 16 + 7) / 8) * 8 - 1:0] s_tdata,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [7:0]            m_tdata,
	input logic                  m_tuser,
	input logic                  m_tlast
);
	import itoa_pkg::*;

	// A waiting input beat holds until taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input beat changed while waiting");

	// A rejected request is one NUL beat closing the run.
	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && (m_tdata == CH_NUL))
		else $error("rejected beat not a lone NUL");

	// The terminator always closes the run.
	a_nul_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata == CH_NUL) |-> m_tlast)
		else $error("NUL not last");

	// The sign only leads a run, never right after a mid-run beat.
	a_sign_leads: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> !(m_tvalid && (m_tdata == CH_MINUS)))
		else $error("minus sign inside a run");

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed under stall");

endmodule

bind integer_to_ascii_radix itoa_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_itoa_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
